>>> sv/btpf_pkg.sv
// Package for the background tile pixel fetch block.
// Holds the item structs, the controller/datapath link structs and fixed constants.
// No dependencies.
package btpf_pkg;

    // Video memory geometry: two byte-wide banks (even / odd byte) of words
    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int WORD_AW    = VRAM_AW - 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE   = 3'd4;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Both tile maps live at 0x1800 + map_select * 0x400: top two address bits set
    localparam logic [1:0] MAP_PREFIX = 2'b11;

    typedef struct packed {
        logic               opcode;
        logic [VRAM_AW-1:0] vram_address;
        logic [7:0]         write_data;
        logic [7:0]         screen_row;
        logic [7:0]         screen_column;
    } in_item_t;

    typedef struct packed {
        logic [1:0] color;
        logic [7:0] pixel_row;
        logic [7:0] pixel_column;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;      // clearing pass: zero one word of both banks
        logic write_en;   // store the accepted write item
        logic map_rd;     // capture the pixel request and read its map entry
        logic tile_rd;    // read both bitplane bytes of the tile line
        logic result_ld;  // form the color and load the result register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // clearing pass is at its final word
    } dp_status_t;

endpackage

>>> sv/btpf_ctrl.sv
// Controller state machine for the background tile pixel fetch block.
// Sequences the clearing pass and the map / tile reads; depends on btpf_pkg.
module btpf_ctrl
    import btpf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    input  logic [7:0] screen_row,
    input  logic [7:0] screen_column,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_TILE  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic accept;
    logic on_screen;

    assign accept    = start && (state_reg == ST_IDLE);
    assign on_screen = ({1'b0, screen_row} < 9'(SCREEN_HEIGHT))
                    && ({1'b0, screen_column} < 9'(SCREEN_WIDTH));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (opcode == OP_PIXEL) && on_screen)
                begin
                    state_next = ST_TILE;
                end
            end
            ST_TILE:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.clear     = (state_reg == ST_CLEAR);
    assign cmd.write_en  = accept && (opcode == OP_WRITE);
    assign cmd.map_rd    = accept && (opcode == OP_PIXEL) && on_screen;
    assign cmd.tile_rd   = (state_reg == ST_TILE);
    assign cmd.result_ld = (state_reg == ST_DONE);
    assign busy          = (state_reg != ST_IDLE);

    // A map read is always followed by the dependent tile read, then the result
    a_map_then_tile: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map_rd |=> cmd.tile_rd)
        else $error("tile read did not follow map read");

    a_tile_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tile_rd |=> cmd.result_ld && !busy == 1'b0)
        else $error("result load did not follow tile read");

    // Nothing is stored while the clearing pass still owns the memory
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !cmd.write_en && !cmd.map_rd)
        else $error("item taken during clearing pass");

endmodule

>>> sv/btpf_datapath.sv
// Datapath for the background tile pixel fetch block: configuration registers,
// banked video memory, tile address and color logic, result register. Uses btpf_pkg.
module btpf_datapath
    import btpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output out_item_t             result,
    output logic                  strobe
);

    localparam int WORDS = VRAM_BYTES / 2;

    // Configuration
    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;
    logic       map_select_reg;
    logic       tile_select_reg;
    logic [7:0] palette_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg    <= '0;
            scroll_y_reg    <= '0;
            map_select_reg  <= 1'b0;
            tile_select_reg <= 1'b0;
            palette_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCROLL_X: scroll_x_reg    <= cfg_data;
                CFG_SCROLL_Y: scroll_y_reg    <= cfg_data;
                CFG_MAP_SEL:  map_select_reg  <= cfg_data[0];
                CFG_TILE_SEL: tile_select_reg <= cfg_data[0];
                CFG_PALETTE:  palette_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clearing pass counter, one word of both banks per cycle
    logic [WORD_AW-1:0] clr_cnt_reg;
    logic [WORD_AW-1:0] clr_cnt_next;

    assign clr_cnt_next      = cmd.clear ? clr_cnt_reg + WORD_AW'(1) : clr_cnt_reg;
    assign status.clear_last = &clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Pixel request capture
    logic [7:0] x_now;
    logic [7:0] y_now;
    logic [VRAM_AW-1:0] map_addr;

    assign x_now    = 8'(request.screen_column + scroll_x_reg);
    assign y_now    = 8'(request.screen_row + scroll_y_reg);
    assign map_addr = {MAP_PREFIX, map_select_reg, y_now[7:3], x_now[7:3]};

    logic [7:0] row_reg;
    logic [7:0] col_reg;
    logic [2:0] x_low_reg;
    logic [2:0] y_low_reg;
    logic       map_odd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.map_rd)
        begin
            row_reg     <= request.screen_row;
            col_reg     <= request.screen_column;
            x_low_reg   <= x_now[2:0];
            y_low_reg   <= y_now[2:0];
            map_odd_reg <= map_addr[0];
        end
    end

    // Video memory: even and odd byte banks share a word address
    logic [7:0] bank_even [WORDS];
    logic [7:0] bank_odd  [WORDS];
    logic [7:0] rd_even_reg;
    logic [7:0] rd_odd_reg;

    logic [WORD_AW-1:0] w_addr;
    logic [7:0]         w_data;
    logic               we_even;
    logic               we_odd;
    logic [WORD_AW-1:0] r_addr;
    logic               re;

    logic [7:0]         tile_idx;
    logic [WORD_AW-1:0] tile_word;

    assign w_addr  = cmd.clear ? clr_cnt_reg : request.vram_address[VRAM_AW-1:1];
    assign w_data  = cmd.clear ? 8'h00 : request.write_data;
    assign we_even = cmd.clear || (cmd.write_en && !request.vram_address[0]);
    assign we_odd  = cmd.clear || (cmd.write_en && request.vram_address[0]);

    // Signed indexing from 0x1000 (negatives land below) when tile select is clear
    assign tile_idx  = map_odd_reg ? rd_odd_reg : rd_even_reg;
    assign tile_word = {!tile_select_reg && !tile_idx[7], tile_idx, y_low_reg};

    assign r_addr = cmd.tile_rd ? tile_word : map_addr[VRAM_AW-1:1];
    assign re     = cmd.map_rd || cmd.tile_rd;

    always_ff @(posedge clk)
    begin
        if (we_even)
        begin
            bank_even[w_addr] <= w_data;
        end
        if (we_odd)
        begin
            bank_odd[w_addr] <= w_data;
        end
        if (re)
        begin
            rd_even_reg <= bank_even[r_addr];
            rd_odd_reg  <= bank_odd[r_addr];
        end
    end

    // Color: leftmost pixel is bit 7 of each plane, plane 1 is the high bit
    logic [2:0] bit_sel;
    logic [1:0] pix;
    logic [7:0] pal_shift;

    assign bit_sel   = ~x_low_reg;
    assign pix       = {rd_odd_reg[bit_sel], rd_even_reg[bit_sel]};
    assign pal_shift = palette_reg >> {pix, 1'b0};

    out_item_t result_reg;
    logic      strobe_reg;
    logic      strobe_next;

    assign strobe_next = cmd.result_ld;

    always_ff @(posedge clk)
    begin
        if (cmd.result_ld)
        begin
            result_reg.color        <= pal_shift[1:0];
            result_reg.pixel_row    <= row_reg;
            result_reg.pixel_column <= col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

>>> sv/background_tile_pixel_fetch_core.sv
// Top level of the background tile pixel fetch block.
// Joins btpf_ctrl and btpf_datapath; depends on btpf_pkg.
//
// Usage: after reset the block sweeps its 8 KiB video memory to zero, one
// 16-bit word (two bytes) per cycle over all 4096 words; busy stays high during
// that pass and configuration writes are taken as usual. An item is taken
// when start is high and busy is low. A write item gives no result, and an
// off-screen pixel request is dropped; busy stays low after either. For an
// on-screen pixel request the map entry is read on the accept edge, the
// dependent tile line is then read in the tile state from the same
// single-read-port memory, and the color is registered in the done state;
// strobe and result show on the following cycle, in which busy is already
// low and a new item may be taken. The result is held for exactly one
// cycle and cannot be stalled, so capture it whenever strobe is high. Write
// configuration only while busy is low and no result is pending.
module background_tile_pixel_fetch_core
    import btpf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              request,
    output out_item_t             result,
    output logic                  strobe,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: clearing pass, accept, map read, tile read, result load
    btpf_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (request.opcode),
        .screen_row    (request.screen_row),
        .screen_column (request.screen_column),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    // Storage, address arithmetic and palette mapping
    btpf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .strobe    (strobe)
    );

endmodule
